### design/mcfir_pkg.sv
// mcfir_pkg: sizes, codes, shared types and the coefficient address helper
// for the multichannel fir filter bank
// depends on nothing
package mcfir_pkg;

    localparam int MAX_TAPS    = 512;
    localparam int MAX_FILTERS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NF_CAP      = (MAX_FILTERS < MAX_RESULTS) ? MAX_FILTERS : MAX_RESULTS;

    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int FILT_W     = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int COEF_DEPTH = MAX_TAPS * MAX_FILTERS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = PROD_W + TAP_W;
    localparam int VALUE_W  = 40;
    localparam int EXT_W    = (ACC_W > VALUE_W + 1) ? ACC_W : VALUE_W + 1;
    localparam int SEEN_W   = 10;
    localparam int SHIFT_W  = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTERS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HISTORY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SHORT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_SHIFT = 3'd4;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               clipped;
    } mac_result_t;

    function automatic logic [COEF_AW-1:0] coef_addr(input logic [FILT_W-1:0] f,
                                                     input logic [TAP_W-1:0]  k);
        return COEF_AW'(f) * COEF_AW'(MAX_TAPS) + COEF_AW'(k);
    endfunction

endpackage

### design/mcfir_window.sv
// mcfir_window: circular sample delay line in one synchronous memory,
// read by sample age; the fill count makes unwritten history read as zero
// depends on mcfir_pkg
module mcfir_window
    import mcfir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic [TAP_W-1:0]           rd_age,
    output logic signed [SAMPLE_W-1:0] rd_data,
    output logic [SEEN_W-1:0]          seen
);

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    logic signed [SAMPLE_W-1:0] window_mem_reg [MAX_TAPS];
    logic [TAP_W-1:0]           wp_reg;
    logic [TAP_W-1:0]           wp_next;
    logic [SEEN_W-1:0]          seen_reg;
    logic [SEEN_W-1:0]          seen_next;
    logic [TAP_W-1:0]           rd_addr;
    logic signed [SAMPLE_W-1:0] mem_q_reg;
    logic                       zero_reg;

    always_comb
    begin
        wp_next = (int'(wp_reg) == MAX_TAPS - 1) ? '0 : wp_reg + 1'b1;
        seen_next = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 1'b1;
        // newest sample sits at wp, older ones below it with wrap
        if (wp_reg >= rd_age)
            rd_addr = wp_reg - rd_age;
        else
            rd_addr = TAP_W'((TAP_W+1)'(wp_reg) + (TAP_W+1)'(MAX_TAPS) - (TAP_W+1)'(rd_age));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            seen_reg <= '0;
        end
        else if (wr_en)
        begin
            wp_reg   <= wp_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            window_mem_reg[wp_next] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= window_mem_reg[rd_addr];
        // ages beyond the samples taken so far are zero history
        zero_reg  <= (int'(rd_age) >= int'(seen_reg));
    end

    assign rd_data = zero_reg ? '0 : mem_q_reg;
    assign seen    = seen_reg;

endmodule

### design/mcfir_coef_store.sv
// mcfir_coef_store: coefficient memory, one filter row of MAX_TAPS after another,
// one write and one registered read per cycle
// depends on mcfir_pkg
module mcfir_coef_store
    import mcfir_pkg::*;
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [COEF_AW-1:0]         wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic [COEF_AW-1:0]         rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] coef_mem_reg [COEF_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            coef_mem_reg[wr_addr] <= wr_data;
        rd_data_reg <= coef_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/mcfir_mac.sv
// mcfir_mac: registered multiply, accumulate, then floor shift and saturation
// of the finished dot product
// depends on mcfir_pkg
module mcfir_mac
    import mcfir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [SAMPLE_W-1:0] coef,
    input  logic [SHIFT_W-1:0]         shift,
    input  logic                       short_mode,
    output logic                       busy,
    output mac_result_t                result
);

    localparam logic signed [EXT_W-1:0] SHORT_MAX = EXT_W'(32767);
    localparam logic signed [EXT_W-1:0] SHORT_MIN = -SHORT_MAX;
    localparam logic signed [EXT_W-1:0] VAL_MAX =
        EXT_W'((longint'(1) <<< (VALUE_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] VAL_MIN = -VAL_MAX - 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [EXT_W-1:0]  acc_ext;
    logic signed [EXT_W-1:0]  shifted;
    logic signed [EXT_W-1:0]  sat;
    logic                     clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else
            prod_valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sample * coef;
        if (ctl.clear)
            acc_reg <= '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    always_comb
    begin
        acc_ext = EXT_W'(acc_reg);
        shifted = acc_ext >>> shift;
        sat     = shifted;
        clip    = 1'b0;
        priority if (short_mode && shifted > SHORT_MAX)
        begin
            sat  = SHORT_MAX;
            clip = 1'b1;
        end
        else if (short_mode && shifted < SHORT_MIN)
        begin
            sat  = SHORT_MIN;
            clip = 1'b1;
        end
        else if (!short_mode && shifted > VAL_MAX)
        begin
            sat  = VAL_MAX;
            clip = 1'b1;
        end
        else if (!short_mode && shifted < VAL_MIN)
        begin
            sat  = VAL_MIN;
            clip = 1'b1;
        end
    end

    assign busy           = prod_valid_reg;
    assign result.value   = sat[VALUE_W-1:0];
    assign result.clipped = clip;

endmodule

### design/multichannel_fir_filter_bank.sv
// multichannel_fir_filter_bank: config registers, tap/filter sequencer and output register
// each filter of a sample runs one tap per cycle on the shared multiply-accumulate,
// and its result waits out any output stall; a coefficient load is taken while idle
// reset: registers go to their defaults; history reads as zero through the fill count,
// no clearing pass; coefficients are undefined until loaded
module multichannel_fir_filter_bank
    import mcfir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic signed [15:0]    sample_value,
    input  logic [3:0]            coef_filter,
    input  logic [8:0]            coef_tap,
    input  logic signed [15:0]    coef_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            filter_index,
    output logic signed [39:0]    filter_value,
    output logic                  clipped,
    output logic                  last_filter,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [9:0]         taps_reg;
    logic [4:0]         filters_reg;
    logic               zero_hist_reg;
    logic               short_reg;
    logic [SHIFT_W-1:0] shift_reg;

    logic [1:0]        state_reg, state_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [FILT_W-1:0] filt_reg, filt_next;
    logic              rd_valid_reg;

    logic                out_valid_reg;
    logic [3:0]          filter_index_reg;
    logic [VALUE_W-1:0]  filter_value_reg;
    logic                clipped_reg;
    logic                last_filter_reg;

    logic [TAP_W:0]      taps_eff;
    logic [FILT_W:0]     nf_eff;
    logic [TAP_W:0]      age_full;
    logic [SEEN_W-1:0]   seen;
    logic [SEEN_W-1:0]   seen_after;
    logic                in_accept;
    logic                take_sample;
    logic                coef_wr;
    logic                emit_ok;
    logic                last_tap;
    logic                last_filt;
    logic                out_free;
    logic                load_out;
    logic                clear_acc;
    logic                mac_busy;
    mac_ctl_t            mac_ctl;
    mac_result_t         mac_res;
    logic signed [SAMPLE_W-1:0] win_data;
    logic signed [SAMPLE_W-1:0] coef_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg      <= 10'd512;
            filters_reg   <= 5'd1;
            zero_hist_reg <= 1'b0;
            short_reg     <= 1'b1;
            shift_reg     <= 5'd15;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TAPS:         taps_reg      <= cfg_data[9:0];
                CFG_FILTERS:      filters_reg   <= cfg_data[4:0];
                CFG_ZERO_HISTORY: zero_hist_reg <= cfg_data[0];
                CFG_OUTPUT_SHORT: short_reg     <= cfg_data[0];
                CFG_RESULT_SHIFT: shift_reg     <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        priority if (taps_reg == '0)
            taps_eff = (TAP_W+1)'(1);
        else if (int'(taps_reg) > MAX_TAPS)
            taps_eff = (TAP_W+1)'(MAX_TAPS);
        else
            taps_eff = (TAP_W+1)'(taps_reg);

        priority if (filters_reg == '0)
            nf_eff = (FILT_W+1)'(1);
        else if (int'(filters_reg) > NF_CAP)
            nf_eff = (FILT_W+1)'(NF_CAP);
        else
            nf_eff = (FILT_W+1)'(filters_reg);
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign take_sample = in_accept && (func == FUNC_SAMPLE);
    assign coef_wr     = in_accept && (func == FUNC_COEF)
                         && (int'(coef_filter) < MAX_FILTERS) && (int'(coef_tap) < MAX_TAPS);

    // fill count as it stands after this sample
    assign seen_after = (seen == '1) ? seen : seen + 1'b1;
    assign emit_ok    = zero_hist_reg || (int'(seen_after) >= int'(taps_eff));

    // tap k meets the sample of age taps-1-k
    assign age_full  = taps_eff - (TAP_W+1)'(1) - (TAP_W+1)'(tap_reg);
    assign last_tap  = ((TAP_W+1)'(tap_reg) == taps_eff - (TAP_W+1)'(1));
    assign last_filt = ((FILT_W+1)'(filt_reg) == nf_eff - (FILT_W+1)'(1));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        filt_next  = filt_reg;
        load_out   = 1'b0;
        clear_acc  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_sample && emit_ok)
                begin
                    state_next = ST_RUN;
                    tap_next   = '0;
                    filt_next  = '0;
                    clear_acc  = 1'b1;
                end
            end
            ST_RUN:
            begin
                tap_next = tap_reg + 1'b1;
                if (last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (last_filt)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next = ST_RUN;
                        filt_next  = filt_reg + 1'b1;
                        tap_next   = '0;
                        clear_acc  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tap_reg      <= '0;
            filt_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            filt_reg     <= filt_next;
            rd_valid_reg <= (state_reg == ST_RUN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            filter_index_reg <= 4'(filt_reg);
            filter_value_reg <= mac_res.value;
            clipped_reg      <= mac_res.clipped;
            last_filter_reg  <= last_filt;
        end
    end

    mcfir_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take_sample),
        .wr_data (sample_value),
        .rd_age  (age_full[TAP_W-1:0]),
        .rd_data (win_data),
        .seen    (seen)
    );

    mcfir_coef_store u_coef (
        .clk     (clk),
        .wr_en   (coef_wr),
        .wr_addr (coef_addr(FILT_W'(coef_filter), TAP_W'(coef_tap))),
        .wr_data (coef_value),
        .rd_addr (coef_addr(filt_reg, tap_reg)),
        .rd_data (coef_data)
    );

    assign mac_ctl.clear = clear_acc;
    assign mac_ctl.valid = rd_valid_reg;

    mcfir_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mac_ctl),
        .sample     (win_data),
        .coef       (coef_data),
        .shift      (shift_reg),
        .short_mode (short_reg),
        .busy       (mac_busy),
        .result     (mac_res)
    );

    assign out_valid    = out_valid_reg;
    assign filter_index = filter_index_reg;
    assign filter_value = filter_value_reg;
    assign clipped      = clipped_reg;
    assign last_filter  = last_filter_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while stalled");

    // the accumulator is complete before a result is taken from it
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (!rd_valid_reg && !mac_busy))
        else $error("result taken with products still in flight");

    // filter counter stays within the filters in use
    a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ((FILT_W+1)'(filt_reg) < nf_eff))
        else $error("filter counter out of range");

    // the final result of a sample carries the last filter number
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && last_filt) |=> (int'(filter_index) == int'(nf_eff) - 1))
        else $error("last filter flag on wrong filter");

endmodule

### dv/fir_bank_scoreboard.sv
`timescale 1ns / 100ps
// fir_bank_tb_pkg: filter bank predictor and result scoreboard for the testbench
// depends on mcfir_pkg for sizes and register indexes
package fir_bank_tb_pkg;

    import mcfir_pkg::*;

    localparam longint FULL_MAX = (64'sd1 <<< (VALUE_W - 1)) - 1;
    localparam longint FULL_MIN = -(64'sd1 <<< (VALUE_W - 1));
    localparam int     SEEN_CAP = 1023;
    localparam int     REPORT_CAP = 50;

    typedef struct packed {
        logic [3:0]         filter_index;
        logic signed [39:0] filter_value;
        logic               clipped;
        logic               last_filter;
    } filter_output_t;

    class fir_bank_scoreboard;

        // history[0] is the newest sample
        logic signed [15:0] history [MAX_TAPS];
        logic signed [15:0] coefs [COEF_DEPTH];
        int                 seen;
        logic [9:0]         taps_reg;
        logic [4:0]         filters_reg;
        logic               zero_hist_reg;
        logic               short_reg;
        logic [4:0]         shift_reg;
        filter_output_t     awaited [$];
        int                 mismatches;
        int                 samples;
        int                 loads;
        int                 checked;

        function new();
            foreach (history[i])
                history[i] = '0;
            foreach (coefs[i])
                coefs[i] = '0;
            seen          = 0;
            taps_reg      = 10'd512;
            filters_reg   = 5'd1;
            zero_hist_reg = 1'b0;
            short_reg     = 1'b1;
            shift_reg     = 5'd15;
            mismatches    = 0;
            samples       = 0;
            loads         = 0;
            checked       = 0;
        endfunction

        function int window_len();
            if (taps_reg == 0)
                return 1;
            if (taps_reg > MAX_TAPS)
                return MAX_TAPS;
            return int'(taps_reg);
        endfunction

        function int bank_size();
            if (filters_reg == 0)
                return 1;
            if (filters_reg > NF_CAP)
                return NF_CAP;
            return int'(filters_reg);
        endfunction

        // cycles the block may still need for one sample under the current settings
        function int busy_cycles();
            return bank_size() * (window_len() + 4) + 16;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TAPS:         taps_reg = data[9:0];
                CFG_FILTERS:      filters_reg = data[4:0];
                CFG_ZERO_HISTORY: zero_hist_reg = data[0];
                CFG_OUTPUT_SHORT: short_reg = data[0];
                CFG_RESULT_SHIFT: shift_reg = data[4:0];
                default:          ;
            endcase
        endfunction

        function filter_output_t filter_dot(int f, int ntaps, int nf);
            filter_output_t r;
            longint         acc;
            longint         v;
            acc = 0;
            // tap 0 meets the oldest sample of the window
            for (int k = 0; k < ntaps; k++)
                acc += longint'(history[ntaps - 1 - k]) * longint'(coefs[f * MAX_TAPS + k]);
            v = acc >>> shift_reg;
            r.clipped = 1'b0;
            if (short_reg)
            begin
                if (v > 32767)
                begin
                    v = 32767;
                    r.clipped = 1'b1;
                end
                else if (v < -32767)
                begin
                    v = -32767;
                    r.clipped = 1'b1;
                end
            end
            else if (v > FULL_MAX)
            begin
                v = FULL_MAX;
                r.clipped = 1'b1;
            end
            else if (v < FULL_MIN)
            begin
                v = FULL_MIN;
                r.clipped = 1'b1;
            end
            r.filter_index = f[3:0];
            r.filter_value = v[39:0];
            r.last_filter  = (f + 1 == nf);
            return r;
        endfunction

        function void note_request(logic func, logic signed [15:0] sample,
                                   logic [3:0] cf, logic [8:0] ct, logic signed [15:0] cv);
            int ntaps;
            int nf;
            if (func == FUNC_COEF)
            begin
                coefs[int'(cf) * MAX_TAPS + int'(ct)] = cv;
                loads++;
                return;
            end
            for (int i = MAX_TAPS - 1; i > 0; i--)
                history[i] = history[i - 1];
            history[0] = sample;
            samples++;
            if (seen < SEEN_CAP)
                seen++;
            ntaps = window_len();
            nf    = bank_size();
            if (!zero_hist_reg && seen < ntaps)
                return;
            for (int f = 0; f < nf; f++)
                awaited.push_back(filter_dot(f, ntaps, nf));
        endfunction

        function void flag(string field, logic signed [40:0] want, logic signed [40:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [3:0] idx, logic signed [39:0] value,
                                   logic clip, logic last);
            filter_output_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none got filter %0d value %0d",
                             $time, idx, value);
                return;
            end
            want = awaited.pop_front();
            checked++;
            flag("filter_index", want.filter_index, idx);
            flag("filter_value", want.filter_value, value);
            flag("clipped", want.clipped, clip);
            flag("last_filter", want.last_filter, last);
        endfunction

    endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives samples, coefficient loads and register writes into the fir filter bank
// depends on mcfir_pkg, fir_bank_tb_pkg and the multichannel_fir_filter_bank rtl
module tb_top;

    import mcfir_pkg::*;
    import fir_bank_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  func = 1'b0;
    logic signed [15:0]    sample_value = '0;
    logic [3:0]            coef_filter = '0;
    logic [8:0]            coef_tap = '0;
    logic signed [15:0]    coef_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [3:0]            filter_index;
    logic signed [39:0]    filter_value;
    logic                  clipped;
    logic                  last_filter;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fir_bank_scoreboard sb;
    bit                 coef_written [COEF_DEPTH];
    bit                 steady = 1'b0;
    int                 settings_used = 0;
    int                 idle_cycles = 0;

    multichannel_fir_filter_bank u_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 24);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(filter_index, filter_value, clipped, last_filter);

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, sb.awaited.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_item(input logic f, input logic signed [15:0] s, input logic [3:0] cf,
                             input logic [8:0] ct, input logic signed [15:0] cv);
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        sample_value <= s;
        coef_filter  <= cf;
        coef_tap     <= ct;
        coef_value   <= cv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(f, s, cf, ct, cv);
    endtask

    task automatic send_sample(input logic signed [15:0] s);
        send_item(FUNC_SAMPLE, s, 4'($urandom), 9'($urandom), 16'($urandom));
    endtask

    task automatic send_coef(input logic [3:0] f, input logic [8:0] k, input logic signed [15:0] v);
        coef_written[int'(f) * MAX_TAPS + int'(k)] = 1'b1;
        send_item(FUNC_COEF, 16'($urandom), f, k, v);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, CFG_DATA_W'(value));
    endtask

    // registers change only once the block has drained
    task automatic write_settings(input int ntaps, input int nfilt, input bit zh, input bit so,
                                  input int shift);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (sb.busy_cycles())
            @(posedge clk);
        write_register(CFG_TAPS, ntaps);
        write_register(CFG_FILTERS, nfilt);
        write_register(CFG_ZERO_HISTORY, zh);
        write_register(CFG_OUTPUT_SHORT, so);
        write_register(CFG_RESULT_SHIFT, shift);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // every coefficient the current settings read must be loaded first
    task automatic load_missing();
        for (int f = 0; f < sb.bank_size(); f++)
            for (int k = 0; k < sb.window_len(); k++)
                if (!coef_written[f * MAX_TAPS + k])
                    send_coef(4'(f), 9'(k), 16'($urandom));
    endtask

    task automatic random_item();
        logic signed [15:0] s;
        int                 ntaps;
        ntaps = sb.window_len();
        if ($urandom_range(0, 99) < 20)
        begin
            if ($urandom_range(0, 1) == 1)
                send_coef(4'($urandom), 9'($urandom_range(0, ntaps - 1)), 16'($urandom));
            else
                send_coef(4'($urandom), 9'($urandom), 16'($urandom));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       s = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
                1:       s = 16'($urandom_range(0, 16)) - 16'sd8;
                default: s = 16'($urandom);
            endcase
            send_sample(s);
        end
    endtask

    task automatic run_phase(input int ntaps, input int nfilt, input bit zh, input bit so,
                             input int shift, input int count, input bit calm);
        write_settings(ntaps, nfilt, zh, so, shift);
        steady = calm;
        load_missing();
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                // hold off until the bank has emitted everything
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.awaited.size() != 0)
                    @(posedge clk);
            end
            random_item();
        end
        in_valid <= 1'b0;
        steady = 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // four taps, three filters, window must fill before any output
        write_settings(4, 3, 0, 1, 15);
        for (int k = 0; k < 4; k++)
            send_coef(4'd0, 9'(k), 16'sh7fff);
        for (int k = 0; k < 4; k++)
            send_coef(4'd1, 9'(k), 16'sh8000);
        send_coef(4'd2, 9'd0, 16'sd1);
        send_coef(4'd2, 9'd1, -16'sd1);
        send_coef(4'd2, 9'd2, 16'sd12345);
        send_coef(4'd2, 9'd3, -16'sd20000);
        send_coef(4'd15, 9'd511, 16'sh8000);
        send_coef(4'd15, 9'd511, 16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd1);
        // full window of max samples saturates both directions in short mode
        repeat (4)
            send_sample(16'sh7fff);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        in_valid <= 1'b0;

        run_phase(1, 16, 1, 1, 0, 40, 0);
        run_phase(0, 0, 0, 0, 31, 30, 0);
        run_phase(16, 5, 1, 0, 0, 60, 1);
        run_phase(7, 31, 0, 1, 15, 60, 0);
        run_phase(33, 2, 1, 1, 20, 40, 0);
        run_phase(3, 9, 0, 0, 5, 50, 0);
        run_phase(2, 16, 0, 1, 15, 50, 0);

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (sb.busy_cycles())
            @(posedge clk);

        $display("run took %0d samples and %0d coefficient loads, %0d results checked",
                 sb.samples, sb.loads, sb.checked);
        $display("%0d register settings: 1 to 33 taps, 1 to 16 filters, both history modes, %s",
                 settings_used, "short and full output, shifts 0 to 31");
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
